>>> hw/rtl/clnws_pkg.sv
// Shared types, constants and command tables for the character LCD nibble write sequencer.
package clnws_pkg;

  // Columns per display row; set-cursor columns at or above this are rejected.
  localparam int unsigned ROW_COLUMNS = 16;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned INIT_BYTES  = 5;
  localparam int unsigned INIT_IDX_W  = $clog2(INIT_BYTES);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_PULSE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_GAP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_UP     = 2'd3;

  // Request function codes.
  localparam logic [2:0] FUNC_COMMAND = 3'd0;
  localparam logic [2:0] FUNC_DATA    = 3'd1;
  localparam logic [2:0] FUNC_CURSOR  = 3'd2;
  localparam logic [2:0] FUNC_CGRAM   = 3'd3;
  localparam logic [2:0] FUNC_INIT    = 3'd4;

  // Fixed command bytes.
  localparam logic [7:0] CMD_RETURN_HOME = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;

  localparam logic [2:0] DDRAM_ROW0_TOP = 3'b100;
  localparam logic [2:0] DDRAM_ROW1_TOP = 3'b110;
  localparam logic [1:0] CGRAM_TOP      = 2'b01;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [4:0] column;
    logic [3:0] glyph_slot;
  } req_t;

  typedef struct packed {
    logic [3:0]  data_nibble;
    logic        reg_select;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;
  } phase_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_BYTE,
    RK_INIT
  } req_kind_t;

  typedef enum logic [1:0] {
    PK_POWER,
    PK_BYTE,
    PK_EXTRA
  } phase_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_BYTE,
    ST_EXTRA
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic                  load;
    logic                  emit;
    phase_kind_t           kind;
    logic [1:0]            phase;
    logic [INIT_IDX_W-1:0] init_idx;
    logic                  init_sel;
    logic                  last;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic      out_free;
    req_kind_t req_kind;
  } dp_status_t;

  function automatic logic [7:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_RETURN_HOME;
      3'd1:    b = CMD_FUNC_SET;
      3'd2:    b = CMD_DISPLAY_ON;
      3'd3:    b = CMD_ENTRY_MODE;
      3'd4:    b = CMD_CLEAR;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/clnws_ctrl.sv
// Controller state machine that steps through the phases of each request.
module clnws_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  clnws_pkg::dp_status_t status,
  output clnws_pkg::dp_cmd_t    cmd
);
  import clnws_pkg::*;

  state_t                state, state_next;
  logic [1:0]            phase, phase_next;
  logic [INIT_IDX_W-1:0] idx, idx_next;
  logic                  init_flag, init_flag_next;
  logic                  accept;

  assign accept = req_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      idx       <= '0;
      init_flag <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      idx       <= idx_next;
      init_flag <= init_flag_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    idx_next       = idx;
    init_flag_next = init_flag;
    case (state)
      ST_IDLE: begin
        phase_next = '0;
        idx_next   = '0;
        if (accept) begin
          case (status.req_kind)
            RK_BYTE: begin
              state_next     = ST_BYTE;
              init_flag_next = 1'b0;
            end
            RK_INIT: begin
              state_next     = ST_POWER;
              init_flag_next = 1'b1;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_POWER: begin
        if (status.out_free) begin
          state_next = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (status.out_free) begin
          phase_next = phase + 2'd1;
          if (phase == 2'd3) begin
            if (!init_flag) begin
              state_next = ST_IDLE;
            end else if (idx == INIT_IDX_W'(INIT_BYTES - 1)) begin
              state_next = ST_EXTRA;
            end else begin
              idx_next = idx + INIT_IDX_W'(1);
            end
          end
        end
      end
      ST_EXTRA: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall    = (state != ST_IDLE);
    cmd          = '0;
    cmd.kind     = PK_BYTE;
    cmd.phase    = phase;
    cmd.init_idx = idx;
    cmd.init_sel = init_flag;
    case (state)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_POWER: begin
        cmd.emit = status.out_free;
        cmd.kind = PK_POWER;
      end
      ST_BYTE: begin
        cmd.emit = status.out_free;
        cmd.last = (phase == 2'd3) && !init_flag;
      end
      ST_EXTRA: begin
        cmd.emit = status.out_free;
        cmd.kind = PK_EXTRA;
        cmd.last = 1'b1;
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/clnws_dp.sv
// Datapath: configuration registers, request decode and the phase output register.
module clnws_dp #(
  parameter int unsigned ROW_COLUMNS = clnws_pkg::ROW_COLUMNS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  clnws_pkg::req_t                     req,
  input  logic                                cfg_we,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  clnws_pkg::dp_cmd_t                  cmd,
  output clnws_pkg::dp_status_t               status,
  output logic                                ph_valid,
  input  logic                                ph_stall,
  output clnws_pkg::phase_t                   ph
);
  import clnws_pkg::*;

  logic [7:0]  enable_pulse_us;
  logic [15:0] nibble_gap_us;
  logic [15:0] settle_us;
  logic [15:0] power_up_us;

  logic [7:0]  req_byte;
  logic        req_rs;
  logic [7:0]  dec_byte;
  logic        dec_rs;
  req_kind_t   dec_kind;
  logic        col_ok;

  logic [7:0]  cur_byte;
  logic [3:0]  cur_nibble;
  phase_t      ph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse_us <= 8'd1;
      nibble_gap_us   <= 16'd200;
      settle_us       <= 16'd2000;
      power_up_us     <= 16'd20000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE_PULSE: enable_pulse_us <= cfg_data[7:0];
        CFG_NIBBLE_GAP:   nibble_gap_us   <= cfg_data;
        CFG_SETTLE:       settle_us       <= cfg_data;
        CFG_POWER_UP:     power_up_us     <= cfg_data;
        default:          power_up_us     <= power_up_us;
      endcase
    end
  end

  assign col_ok = {1'b0, req.column} < 6'(ROW_COLUMNS);

  // Work out the byte to send and whether the request yields any phases at all.
  always_comb begin
    dec_byte = req.byte_value;
    dec_rs   = 1'b0;
    dec_kind = RK_NONE;
    case (req.func)
      FUNC_COMMAND: dec_kind = RK_BYTE;
      FUNC_DATA: begin
        dec_rs   = 1'b1;
        dec_kind = RK_BYTE;
      end
      FUNC_CURSOR: begin
        if (req.row == 2'd0) begin
          dec_byte = {DDRAM_ROW0_TOP, req.column};
        end else begin
          dec_byte = {DDRAM_ROW1_TOP, req.column};
        end
        if (col_ok && (req.row inside {2'd0, 2'd1})) begin
          dec_kind = RK_BYTE;
        end
      end
      FUNC_CGRAM: begin
        dec_byte = {CGRAM_TOP, req.glyph_slot[2:0], 3'b000};
        if (!req.glyph_slot[3]) begin
          dec_kind = RK_BYTE;
        end
      end
      FUNC_INIT: dec_kind = RK_INIT;
      default:   dec_kind = RK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_byte <= dec_byte;
      req_rs   <= dec_rs;
    end
  end

  assign cur_byte   = cmd.init_sel ? init_byte(cmd.init_idx) : req_byte;
  assign cur_nibble = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];

  always_comb begin
    ph_next      = '0;
    ph_next.last = cmd.last;
    case (cmd.kind)
      PK_POWER: begin
        ph_next.hold_us = power_up_us;
      end
      PK_EXTRA: begin
        // The pins stay where the clear command left them.
        ph_next.data_nibble = CMD_CLEAR[3:0];
        ph_next.hold_us     = settle_us;
      end
      default: begin
        ph_next.data_nibble = cur_nibble;
        ph_next.reg_select  = cmd.init_sel ? 1'b0 : req_rs;
        ph_next.enable      = !cmd.phase[0];
        if (!cmd.phase[0]) begin
          ph_next.hold_us = {8'd0, enable_pulse_us};
        end else if (cmd.phase[1]) begin
          ph_next.hold_us = settle_us;
        end else begin
          ph_next.hold_us = nibble_gap_us;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_valid <= 1'b0;
    end else if (cmd.emit) begin
      ph_valid <= 1'b1;
    end else if (!ph_stall) begin
      ph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ph <= ph_next;
    end
  end

  assign status.out_free = !ph_valid || !ph_stall;
  assign status.req_kind = dec_kind;

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer.
//
//  port group   direction  handshake             payload
//  req          in         req_valid/req_stall   func, byte_value, row, column, glyph_slot
//  ph           out        ph_valid/ph_stall     data_nibble, reg_select, enable, hold_us, last
//  cfg          in         cfg_we                cfg_index, cfg_data
//
// One request is taken at a time. A byte request is decoded and loaded on acceptance,
// then goes out as four phases, one phase per cycle while ph is not stalled; init sends
// a power-up phase, five command bytes and an extra settle phase, and a request that
// yields no phases is dropped without leaving idle. The phase counter in the controller
// steps the phases. Reset restores the register defaults and leaves the block idle and ready.
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned ROW_COLUMNS = clnws_pkg::ROW_COLUMNS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  clnws_pkg::req_t                   req,
  output logic                              ph_valid,
  input  logic                              ph_stall,
  output clnws_pkg::phase_t                 ph,
  input  logic                              cfg_we,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import clnws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  clnws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  clnws_dp #(
    .ROW_COLUMNS (ROW_COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .ph_valid  (ph_valid),
    .ph_stall  (ph_stall),
    .ph        (ph)
  );

endmodule

>>> verif/char_lcd_phase_checker.sv
`timescale 1ns / 1ps
// Pin phase predictor and checker for the character LCD nibble write sequencer.
module char_lcd_phase_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  clnws_pkg::req_t                   req,
  input  logic                              ph_valid,
  input  logic                              ph_stall,
  input  clnws_pkg::phase_t                 ph,
  input  logic                              cfg_we,
  input  logic [clnws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clnws_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                phases_due,
  output int                                mismatches
);
  import clnws_pkg::*;

  localparam logic [7:0] DDRAM_ROW0_BASE = 8'h80;
  localparam logic [7:0] DDRAM_ROW1_BASE = 8'hC0;
  localparam logic [7:0] CGRAM_BASE      = 8'h40;

  logic [7:0]  strobe_us;
  logic [15:0] gap_us;
  logic [15:0] settle_hold_us;
  logic [15:0] power_hold_us;
  phase_t      pin_phases_ahead[$];
  int          errors = 0;

  function automatic void queue_phase(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
    phase_t p;
    p.data_nibble = nib;
    p.reg_select  = rs;
    p.enable      = en;
    p.hold_us     = hold;
    p.last        = 1'b0;
    pin_phases_ahead.push_back(p);
  endfunction

  // A byte goes out as two strobed nibbles, high nibble first.
  function automatic void queue_byte(logic [7:0] b, logic rs);
    queue_phase(b[7:4], rs, 1'b1, {8'h00, strobe_us});
    queue_phase(b[7:4], rs, 1'b0, gap_us);
    queue_phase(b[3:0], rs, 1'b1, {8'h00, strobe_us});
    queue_phase(b[3:0], rs, 1'b0, settle_hold_us);
  endfunction

  function automatic void expand_request(req_t r);
    int     first;
    phase_t tail;
    first = pin_phases_ahead.size();
    case (r.func)
      FUNC_COMMAND: queue_byte(r.byte_value, 1'b0);
      FUNC_DATA:    queue_byte(r.byte_value, 1'b1);
      FUNC_CURSOR: begin
        if (r.column < ROW_COLUMNS) begin
          if (r.row == 2'd0) queue_byte(DDRAM_ROW0_BASE | {3'b000, r.column}, 1'b0);
          else if (r.row == 2'd1) queue_byte(DDRAM_ROW1_BASE | {3'b000, r.column}, 1'b0);
        end
      end
      FUNC_CGRAM: begin
        if (r.glyph_slot < 4'd8) queue_byte(CGRAM_BASE + {r.glyph_slot[2:0], 3'b000}, 1'b0);
      end
      FUNC_INIT: begin
        queue_phase(4'h0, 1'b0, 1'b0, power_hold_us);
        queue_byte(CMD_RETURN_HOME, 1'b0);
        queue_byte(CMD_FUNC_SET, 1'b0);
        queue_byte(CMD_DISPLAY_ON, 1'b0);
        queue_byte(CMD_ENTRY_MODE, 1'b0);
        queue_byte(CMD_CLEAR, 1'b0);
        // The pins keep the clear command's final state for the extra settle.
        queue_phase(4'h1, 1'b0, 1'b0, settle_hold_us);
      end
      default: ;
    endcase
    if (pin_phases_ahead.size() > first) begin
      tail = pin_phases_ahead.pop_back();
      tail.last = 1'b1;
      pin_phases_ahead.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    phase_t want;
    if (rst) begin
      strobe_us      = 8'd1;
      gap_us         = 16'd200;
      settle_hold_us = 16'd2000;
      power_hold_us  = 16'd20000;
      pin_phases_ahead.delete();
    end else begin
      // Compare before expanding, since a phase seen now belongs to an earlier request.
      if (ph_valid && !ph_stall) begin
        if (pin_phases_ahead.size() == 0) begin
          if (errors < 10) $display("unexpected phase: %p", ph);
          errors = errors + 1;
        end else begin
          want = pin_phases_ahead.pop_front();
          if (ph.data_nibble !== want.data_nibble || ph.reg_select !== want.reg_select ||
              ph.enable !== want.enable || ph.hold_us !== want.hold_us ||
              ph.last !== want.last) begin
            if (errors < 10)
              $display("phase mismatch: expected nib %h rs %b en %b hold %0d last %b,",
                       want.data_nibble, want.reg_select, want.enable, want.hold_us,
                       want.last,
                       " got nib %h rs %b en %b hold %0d last %b",
                       ph.data_nibble, ph.reg_select, ph.enable, ph.hold_us, ph.last);
            errors = errors + 1;
          end
        end
      end
      if (req_valid && !req_stall) expand_request(req);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE_PULSE: strobe_us      = cfg_data[7:0];
          CFG_NIBBLE_GAP:   gap_us         = cfg_data;
          CFG_SETTLE:       settle_hold_us = cfg_data;
          CFG_POWER_UP:     power_hold_us  = cfg_data;
          default: ;
        endcase
      end
    end
    phases_due <= pin_phases_ahead.size();
    mismatches <= errors;
  end

endmodule

>>> verif/char_lcd_nibble_write_sequencer_test.sv
`timescale 1ns / 1ps
// Top of the testbench: request stimulus, register settings, output stalls and the verdict.
module char_lcd_nibble_write_sequencer_test;
  import clnws_pkg::*;

  localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  req_t                   req;
  logic                   ph_valid;
  logic                   ph_stall;
  phase_t                 ph;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     phases_due;
  int                     mismatches;
  bit                     hold_off_wanted = 1'b0;

  char_lcd_nibble_write_sequencer dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .ph_valid(ph_valid), .ph_stall(ph_stall), .ph(ph),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  char_lcd_phase_checker phase_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .ph_valid(ph_valid), .ph_stall(ph_stall), .ph(ph),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .phases_due(phases_due), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("char_lcd_nibble_write_sequencer_test failed");
    $finish;
  end

  function automatic req_t make_req(logic [2:0] f, logic [7:0] b, logic [1:0] r,
                                    logic [4:0] c, logic [3:0] s);
    req_t q;
    q.func       = f;
    q.byte_value = b;
    q.row        = r;
    q.column     = c;
    q.glyph_slot = s;
    return q;
  endfunction

  // Mostly well-formed requests; a minority fall out of range or use spare codes.
  function automatic req_t random_request();
    req_t q;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      q.func = FUNC_COMMAND;
    else if (pick < 55) q.func = FUNC_DATA;
    else if (pick < 72) q.func = FUNC_CURSOR;
    else if (pick < 87) q.func = FUNC_CGRAM;
    else if (pick < 93) q.func = FUNC_INIT;
    else                q.func = FUNC_SPARE_5 + 3'($urandom_range(0, 2));
    q.byte_value = 8'($urandom_range(0, 255));
    q.row        = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
    q.column     = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(16, 31))
                                               : 5'($urandom_range(0, 15));
    q.glyph_slot = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
    return q;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and keep it until taken; valid stays high when no gap follows.
  task automatic send(input req_t r, input int gap);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_regs(input logic [15:0] pulse, input logic [15:0] gap,
                            input logic [15:0] settle, input logic [15:0] power);
    logic [CFG_INDEX_W-1:0] idx[4];
    logic [15:0]            vals[4];
    idx  = '{CFG_ENABLE_PULSE, CFG_NIBBLE_GAP, CFG_SETTLE, CFG_POWER_UP};
    vals = '{pulse, gap, settle, power};
    req_valid <= 1'b0;
    do @(posedge clk); while (phases_due != 0);
    // A request with no phases may still be in decode; give it time to drain.
    repeat (30) @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Output side: random stall bursts, free stretches and one long hold-off on request.
  initial begin
    int n;
    bit hold_off_done;
    hold_off_done = 1'b0;
    ph_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_wanted && !hold_off_done) begin
        hold_off_done = 1'b1;
        ph_stall <= 1'b1;
        n = 400;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            ph_stall <= 1'b0;
            n = $urandom_range(1, 12);
          end
          5: begin
            ph_stall <= 1'b0;
            n = $urandom_range(40, 120);
          end
          6, 7, 8: begin
            ph_stall <= 1'b1;
            n = $urandom_range(1, 3);
          end
          default: begin
            ph_stall <= 1'b1;
            n = $urandom_range(10, 40);
          end
        endcase
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset register values.
    send(make_req(FUNC_COMMAND, 8'h00, 2'd0, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_COMMAND, 8'hFF, 2'd0, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_DATA, 8'hA5, 2'd3, 5'd31, 4'd15), pick_gap());
    send(make_req(FUNC_DATA, 8'h5A, 2'd0, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'h00, 2'd0, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'hFF, 2'd1, 5'd15, 4'd15), pick_gap());
    send(make_req(FUNC_CURSOR, 8'h00, 2'd0, 5'd16, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'h00, 2'd1, 5'd31, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'h00, 2'd2, 5'd3, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'h00, 2'd3, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_CURSOR, 8'hFF, 2'd1, 5'd0, 4'd9), pick_gap());
    send(make_req(FUNC_CGRAM, 8'h00, 2'd0, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_CGRAM, 8'hFF, 2'd3, 5'd31, 4'd7), pick_gap());
    send(make_req(FUNC_CGRAM, 8'h00, 2'd0, 5'd0, 4'd8), pick_gap());
    send(make_req(FUNC_CGRAM, 8'h00, 2'd0, 5'd0, 4'd15), pick_gap());
    send(make_req(FUNC_INIT, 8'hFF, 2'd3, 5'd31, 4'd15), pick_gap());
    send(make_req(FUNC_SPARE_5, 8'h12, 2'd0, 5'd1, 4'd2), pick_gap());
    send(make_req(FUNC_SPARE_6, 8'h00, 2'd1, 5'd0, 4'd0), pick_gap());
    send(make_req(FUNC_SPARE_7, 8'hFF, 2'd3, 5'd31, 4'd15), pick_gap());
    send(make_req(FUNC_COMMAND, 8'h0F, 2'd3, 5'd31, 4'd15), 0);

    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: write_regs(16'd1, 16'd1, 16'd1, 16'd1);
        1: write_regs(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_regs(16'd0, 16'd0, 16'd0, 16'd0);
        // Bits above the pulse register's width must be dropped.
        3: write_regs(16'hA500 | 16'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        default: write_regs(16'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                            16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      endcase
      if (seg == 1) hold_off_wanted = 1'b1;
      for (int i = 0; i < 40; i++) begin
        // One setting runs with the request side never idling.
        send(random_request(), (seg == 2) ? 0 : pick_gap());
      end
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (phases_due != 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("char_lcd_nibble_write_sequencer_test passed");
    end else begin
      $display("char_lcd_nibble_write_sequencer_test failed");
    end
    $finish;
  end

endmodule
